// ===== rtl/spq_pkg.sv =====
// ============================================================================
// spq_pkg: shared types and constants of the sorted priority queue
// Request codes, the per-cell operation and the control bundle that the
// top level hands to every cell of the chain.
// ============================================================================
package spq_pkg;

    // Width of the fixed fields on the request and result channels.
    localparam int REQ_BITS   = 3;
    localparam int KEY_W      = 32;
    localparam int COUNT_W    = 5;

    // Request codes.
    localparam logic [REQ_BITS-1:0] REQ_INSERT   = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_POP_MAX  = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_POP_MIN  = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_CONTAINS = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR    = 3'd4;

    // What each cell does at the next accepted item.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    // Control bundle for one cell.
    typedef struct packed {
        cell_op_t op;
        logic     occ;
    } cell_ctrl_t;

endpackage

// ===== rtl/spq_req_if.sv =====
// ============================================================================
// spq_req_if: request channel of the sorted priority queue
// Valid/ready channel carrying the request code and the key.
// ============================================================================
interface spq_req_if
    import spq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [REQ_BITS-1:0]        req_type;
    logic signed [KEY_W-1:0]    key_in;

    modport source (output valid, output req_type, output key_in, input ready);
    modport sink   (input valid, input req_type, input key_in, output ready);
endinterface

// ===== rtl/spq_rsp_if.sv =====
// ============================================================================
// spq_rsp_if: result channel of the sorted priority queue
// Valid/ready channel carrying one result item per request.
// ============================================================================
interface spq_rsp_if
    import spq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic signed [KEY_W-1:0]    popped_key;
    logic                       found;
    logic [COUNT_W-1:0]         entry_count;
    logic signed [KEY_W-1:0]    front_key;
    logic signed [KEY_W-1:0]    tail_key;

    modport source (output valid, output ok, output popped_key, output found,
                    output entry_count, output front_key, output tail_key,
                    input ready);
    modport sink   (input valid, input ok, input popped_key, input found,
                    input entry_count, input front_key, input tail_key,
                    output ready);
endinterface

// ===== rtl/sorted_priority_queue_core.sv =====
// ============================================================================
// sorted_priority_queue_core: bounded priority queue of sorted signed keys
// A chain of key cells kept in descending order; inserts, front pops and
// membership tests act on all cells in parallel.
// ============================================================================
// A result item appears in the cycle after its request is accepted.
// Throughput: one item per cycle while results are taken; each insert or
// front pop is a single parallel compare-and-shift across the cell chain.
// Reset clears the entry count and the result valid flag; key cells are
// not reset and hold no meaning until written.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        valid_reg;
    logic                        ok_reg;
    logic                        ok_next;
    logic signed [KEY_W-1:0]     popped_reg;
    logic signed [KEY_W-1:0]     popped_next;
    logic                        found_reg;
    logic                        found_next;
    logic                        accept;
    logic                        full;
    logic                        empty;
    cell_op_t                    op;
    logic signed [KEY_BITS-1:0]  key_ext;
    logic signed [KEY_BITS-1:0]  cell_key  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]      cell_keep;
    logic [QUEUE_DEPTH-1:0]      cell_hit;
    logic [QUEUE_DEPTH-1:0]      ordered;
    logic [IW-1:0]               tail_idx;

    assign accept  = req.valid && req.ready;
    assign req.ready = !valid_reg || rsp.ready;
    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign key_ext = KEY_BITS'(req.key_in);
    assign tail_idx = IW'(count_reg - CW'(1));

    // Decode the request into the cell operation, next count and result.
    always_comb
    begin
        op          = CELL_HOLD;
        count_next  = count_reg;
        ok_next     = 1'b0;
        popped_next = '0;
        found_next  = 1'b0;
        case (req.req_type)
            REQ_INSERT:
            begin
                if (!full)
                begin
                    op         = CELL_INSERT;
                    count_next = count_reg + CW'(1);
                    ok_next    = 1'b1;
                end
            end
            REQ_POP_MAX:
            begin
                if (!empty)
                begin
                    op          = CELL_SHIFT;
                    count_next  = count_reg - CW'(1);
                    ok_next     = 1'b1;
                    popped_next = KEY_W'(cell_key[0]);
                end
            end
            REQ_POP_MIN:
            begin
                if (!empty)
                begin
                    count_next  = count_reg - CW'(1);
                    ok_next     = 1'b1;
                    popped_next = KEY_W'(cell_key[tail_idx]);
                end
            end
            REQ_CONTAINS:
            begin
                ok_next    = 1'b1;
                found_next = |cell_hit;
            end
            REQ_CLEAR:
            begin
                count_next = '0;
                ok_next    = 1'b1;
            end
            default:
            begin
                op = CELL_HOLD;
            end
        endcase
    end

    // The chain of cells; the first cell sees the new key as its left key.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        cell_ctrl_t                 ctrl;
        logic signed [KEY_BITS-1:0] left_key;
        logic signed [KEY_BITS-1:0] right_key;
        logic                       left_keep;

        assign ctrl.op  = accept ? op : CELL_HOLD;
        assign ctrl.occ = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_key  = key_ext;
            assign left_keep = 1'b0;
        end
        else
        begin : g_inner
            assign left_key  = cell_key[i-1];
            assign left_keep = cell_keep[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_key = cell_key[i];
        end
        else
        begin : g_body
            assign right_key = cell_key[i+1];
        end

        spq_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .key_in    (key_ext),
            .left_key  (left_key),
            .left_keep (left_keep),
            .right_key (right_key),
            .key       (cell_key[i]),
            .keep      (cell_keep[i]),
            .hit       (cell_hit[i])
        );

        // Occupied neighbors stay in descending order.
        if (i == 0)
        begin : g_ord_first
            assign ordered[i] = 1'b1;
        end
        else
        begin : g_ord
            assign ordered[i] = !(CW'(i) < count_reg) || (cell_key[i-1] >= cell_key[i]);
        end
    end

    // Count and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg     <= ok_next;
            popped_reg <= popped_next;
            found_reg  <= found_next;
        end
    end

    // Count, front and tail follow the queue state, which holds while a
    // result waits.
    assign rsp.valid       = valid_reg;
    assign rsp.ok          = ok_reg;
    assign rsp.popped_key  = popped_reg;
    assign rsp.found       = found_reg;
    assign rsp.entry_count = COUNT_W'(count_reg);
    assign rsp.front_key   = empty ? '0 : KEY_W'(cell_key[0]);
    assign rsp.tail_key    = empty ? '0 : KEY_W'(cell_key[tail_idx]);

    // The count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // A waiting result blocks new requests.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !rsp.ready) |-> !req.ready)
        else $error("request accepted while result stalled");

    // A clear empties the queue.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries behind");

    // An insert into a full queue leaves the count alone.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_INSERT && full) |=> $stable(count_reg))
        else $error("insert into full queue changed count");

    // Stored keys stay sorted.
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        &ordered)
        else $error("queue lost descending order");

endmodule

// ===== rtl/spq_cell.sv =====
// ============================================================================
// spq_cell: one entry of the shift-register priority queue
// Holds one key, compares it with the incoming key and either keeps it,
// takes the new key, takes its left neighbor's key or its right neighbor's.
// ============================================================================
module spq_cell
    import spq_pkg::*;
#(
    parameter int KEY_BITS = 32
)(
    input  logic                       clk,
    input  cell_ctrl_t                 ctrl,
    input  logic signed [KEY_BITS-1:0] key_in,
    input  logic signed [KEY_BITS-1:0] left_key,
    input  logic                       left_keep,
    input  logic signed [KEY_BITS-1:0] right_key,
    output logic signed [KEY_BITS-1:0] key,
    output logic                       keep,
    output logic                       hit
);

    logic signed [KEY_BITS-1:0] key_reg;
    logic signed [KEY_BITS-1:0] key_next;

    // An occupied entry that is not below the new key stays in place.
    assign keep = ctrl.occ && (key_reg >= key_in);
    assign hit  = ctrl.occ && (key_reg == key_in);
    assign key  = key_reg;

    // Cells ahead of the insert point keep, the insert point takes the new
    // key, and cells behind it take their left neighbor's key.
    always_comb
    begin
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (keep)
                    key_next = key_reg;
                else if (left_keep)
                    key_next = key_in;
                else
                    key_next = left_key;
            end
            CELL_SHIFT: key_next = right_key;
            default:    key_next = key_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== tb/sorted_priority_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sorted_priority_queue_core_tb: self-checking testbench of the sorted queue
// Drives requests over the valid/ready request channel, keeps its own sorted
// copy of the queue to work out every result, and compares each result item
// field by field. Directed tests cover the empty and full queue, extreme and
// duplicate keys, and unused request codes. A stalled receiver fills the
// block, and random traffic runs under several idle and stall patterns.
// ============================================================================
module sorted_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int REQ_CODE_MAX  = (1 << REQ_BITS) - 1;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 20;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int MAX_REPORTS   = 10;

    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    // One result item as the block reports it.
    typedef struct {
        logic                    ok;
        logic signed [KEY_W-1:0] popped_key;
        logic                    found;
        logic [COUNT_W-1:0]      entry_count;
        logic signed [KEY_W-1:0] front_key;
        logic signed [KEY_W-1:0] tail_key;
    } queue_result_t;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_BITS    (KEY_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Sorted copy of the queue, largest key at index 0.
    logic signed [KEY_W-1:0] shadow_keys [QUEUE_DEPTH];
    int                      shadow_count;

    queue_result_t pending_results [$];
    int            error_count;
    int            send_idle_pct;
    int            rsp_stall_pct;
    logic          hold_pending;
    int            hold_left;

    // Clock.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Applies one request to the shadow queue and returns the result it causes.
    function automatic queue_result_t queue_predict(input logic [REQ_BITS-1:0] code,
                                                    input logic signed [KEY_W-1:0] key);
        queue_result_t res;
        int            pos;
        int            i;
        res.ok         = 1'b0;
        res.popped_key = '0;
        res.found      = 1'b0;
        case (code)
            REQ_INSERT:
            begin
                if (shadow_count < QUEUE_DEPTH)
                begin
                    // New key goes behind every key greater than or equal to it.
                    pos = 0;
                    while (pos < shadow_count && !(shadow_keys[pos] < key))
                        pos++;
                    for (i = shadow_count; i > pos; i--)
                        shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[pos] = key;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            REQ_POP_MAX:
            begin
                if (shadow_count > 0)
                begin
                    res.popped_key = shadow_keys[0];
                    for (i = 1; i < shadow_count; i++)
                        shadow_keys[i-1] = shadow_keys[i];
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
            REQ_POP_MIN:
            begin
                if (shadow_count > 0)
                begin
                    res.popped_key = shadow_keys[shadow_count-1];
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
            REQ_CONTAINS:
            begin
                for (i = 0; i < shadow_count; i++)
                    if (shadow_keys[i] == key)
                        res.found = 1'b1;
                res.ok = 1'b1;
            end
            REQ_CLEAR:
            begin
                shadow_count = 0;
                res.ok = 1'b1;
            end
            default:
            begin
                // Unused codes change nothing and fail.
            end
        endcase
        res.entry_count = COUNT_W'(shadow_count);
        res.front_key   = (shadow_count > 0) ? shadow_keys[0] : '0;
        res.tail_key    = (shadow_count > 0) ? shadow_keys[shadow_count-1] : '0;
        return res;
    endfunction

    // Sends one request item, with a random idle gap ahead of it.
    task automatic send_request(input logic [REQ_BITS-1:0] code,
                                input logic signed [KEY_W-1:0] key);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= code;
        req_ch.key_in   <= key;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(queue_predict(code, key));
    endtask

    // Random key: a narrow range in 40 percent of picks, so duplicates and hits are common.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return $signed(KEY_W'($urandom_range(6))) - 3;
        if (r < 55)
        begin
            case ($urandom_range(3))
                0: return KEY_MAX;
                1: return KEY_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        return $signed(KEY_W'($urandom));
    endfunction

    // Random request; the fill trend drives the queue toward full or empty.
    task automatic send_random_request(input logic filling);
        int unsigned           r;
        logic [REQ_BITS-1:0]   code;
        logic signed [KEY_W-1:0] key;
        r   = $urandom_range(99);
        key = pick_key();
        if (r < 2)
            code = REQ_CLEAR;
        else if (r < 4)
            code = REQ_BITS'($urandom_range(int'(REQ_CLEAR) + 1, REQ_CODE_MAX));
        else if (r < 20)
        begin
            code = REQ_CONTAINS;
            // On a non-empty queue, half the membership tests look for a key that is stored.
            if (shadow_count > 0 && $urandom_range(1) == 1)
                key = shadow_keys[$urandom_range(shadow_count - 1)];
        end
        else if (r < (filling ? 75 : 45))
            code = REQ_INSERT;
        else
            code = ($urandom_range(1) == 1) ? REQ_POP_MAX : REQ_POP_MIN;
        send_request(code, key);
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_pending)
        begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Result checker: each result against the oldest expectation.
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result item at %0t", $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.ok !== want.ok || rsp_ch.popped_key !== want.popped_key ||
                    rsp_ch.found !== want.found || rsp_ch.entry_count !== want.entry_count ||
                    rsp_ch.front_key !== want.front_key || rsp_ch.tail_key !== want.tail_key)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("ERROR at %0t: expected ok=%0b popped=%0d found=%0b",
                                 $realtime, want.ok, want.popped_key, want.found);
                        $display("       expected count=%0d front=%0d tail=%0d",
                                 want.entry_count, want.front_key, want.tail_key);
                        $display("       actual   ok=%0b popped=%0d found=%0b",
                                 rsp_ch.ok, rsp_ch.popped_key, rsp_ch.found);
                        $display("       actual   count=%0d front=%0d tail=%0d",
                                 rsp_ch.entry_count, rsp_ch.front_key, rsp_ch.tail_key);
                    end
                end
            end
        end
    end

    // Pops, clear and an unused code on an empty queue.
    task automatic test_empty_queue();
        send_request(REQ_POP_MAX, KEY_MAX);
        send_request(REQ_POP_MIN, KEY_MIN);
        send_request(REQ_CLEAR, '0);
        send_request(REQ_BITS'(REQ_CODE_MAX), '1);
    endtask

    // Fills with extreme and duplicate keys, overflows, then searches, pops and clears.
    task automatic test_fill_and_overflow();
        logic signed [KEY_W-1:0] fill_keys [QUEUE_DEPTH];
        int i;
        fill_keys = '{KEY_MAX, KEY_MIN, 0, -1, 1, 5, 5, 5, -5, 100, -100,
                      KEY_MAX, KEY_MIN, 32'sh5555_5555, 32'shAAAA_AAAA, 2};
        for (i = 0; i < QUEUE_DEPTH; i++)
            send_request(REQ_INSERT, fill_keys[i]);
        send_request(REQ_INSERT, 3);
        send_request(REQ_CONTAINS, 5);
        send_request(REQ_CONTAINS, 3);
        send_request(REQ_POP_MAX, '0);
        send_request(REQ_POP_MIN, '0);
        send_request(REQ_CLEAR, '0);
    endtask

    // Receiver holds off while requests keep coming, so the input stalls.
    task automatic test_backpressure(input int n_items);
        int i;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_pending  = 1'b1;
        for (i = 0; i < n_items; i++)
            send_random_request(1'b1);
    endtask

    // Random traffic under one idle and stall pattern.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        logic filling;
        int   i;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        filling       = 1'b1;
        for (i = 0; i < n_items; i++)
        begin
            if ($urandom_range(39) == 0)
                filling = ~filling;
            send_random_request(filling);
        end
    endtask

    // Run limit.
    initial
    begin
        #(TIMEOUT_NS);
        $display("sorted_priority_queue_core_tb NOT OK");
        $finish;
    end

    // Test sequence.
    initial
    begin
        error_count     = 0;
        shadow_count    = 0;
        send_idle_pct   = 0;
        rsp_stall_pct   = 0;
        hold_pending    = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.key_in   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_and_overflow();
        test_backpressure(40);
        test_random_traffic(0, 0, 420);
        test_random_traffic(52, 0, 420);
        test_random_traffic(0, 52, 420);
        test_random_traffic(34, 34, 420);

        // Let every outstanding result come back.
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sorted_priority_queue_core_tb OK");
        else
            $display("sorted_priority_queue_core_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
tb/sorted_priority_queue_core_tb.sv
